[rtl/vpd_pkg.sv]
// shared types, widths and constants for the vertex projection and divide pipeline
`timescale 1ns / 1ps
`default_nettype none

package vpd_pkg;

  // field and coefficient formats
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned LANES      = 4;
  localparam int unsigned PAIRS      = LANES / 2;
  localparam int unsigned ROW_W      = COEF_W * LANES;
  localparam int unsigned FRAC_COEF  = 12;
  localparam int unsigned FRAC_COORD = 16;

  // datapath widths
  localparam int unsigned PROD_W    = COORD_W + COEF_W;
  localparam int unsigned PAIR_W    = PROD_W + 1;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned PROJ_W    = ACC_W - FRAC_COEF;
  localparam int unsigned MAG_W     = PROJ_W;
  localparam int unsigned NUM_W     = MAG_W + FRAC_COORD + 1;
  localparam int unsigned QUO_W     = COORD_W;
  localparam int unsigned DIV_LANES = LANES - 1;

  // pipeline shape
  localparam int unsigned MM_STAGES   = 3;
  localparam int unsigned PREP_STAGES = 3;
  localparam int unsigned PIPE_DEPTH  = MM_STAGES + PREP_STAGES + QUO_W + 1;
  localparam int unsigned OCC_W       = $clog2(PIPE_DEPTH + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_ROW3
  } vpd_reg_e;

  // identity matrix after reset
  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  localparam logic signed [ACC_W-1:0] LANE_ROUND = ACC_W'(1 << (FRAC_COEF - 1));
  localparam logic [COORD_W-1:0] Q_ONE     = COORD_W'(1 << FRAC_COORD);
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic signed [COORD_W-1:0] in_w;
  } vpd_vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_w;
    logic                      w_was_zero;
    logic                      saturated;
  } vpd_result_t;

  // one divide lane: partial remainder, numerator bits shifting out while
  // quotient bits shift in, result sign and overflow
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] nq;
    logic             neg;
    logic             ovf;
  } vpd_div_lane_t;

  typedef struct packed {
    vpd_div_lane_t [DIV_LANES-1:0] lane;
    logic [MAG_W-1:0]              dvs;
    logic                          wz;
  } vpd_div_t;

endpackage

`default_nettype wire

[rtl/vpd_stream_if.sv]
// valid/ready stream channel carrying one payload item
`timescale 1ns / 1ps
`default_nettype none

interface vpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/vertex_projection_divide.sv]
// Vertex projection with perspective divide.
// 39 register stages (3 multiply/sum, 3 divide setup, 32 divider, result register).
// Throughput: one vertex per cycle unless the output stalls; 32 divider stages set the depth.
// Stalls hold every stage; empty stages keep filling, so input is taken while any stage is free.
// Reset clears all valid flags and loads the identity matrix into the row registers.
`timescale 1ns / 1ps
`default_nettype none

module vertex_projection_divide import vpd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ROW_W-1:0]     cfg_wdata_i,
  vpd_stream_if.sink                vtx_i,
  vpd_stream_if.source              res_o
);

  logic [LANES-1:0][ROW_W-1:0] rows_q;

  logic                         mm_valid, mm_ready;
  logic [LANES-1:0][PROJ_W-1:0] mm_proj;

  logic     div_valid [QUO_W+1];
  logic     div_ready [QUO_W+1];
  vpd_div_t div_data  [QUO_W+1];

  logic [OCC_W-1:0] occ_q;
  logic             in_acc, out_acc;

  // matrix row registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= ROW0_RESET;
      rows_q[1] <= ROW1_RESET;
      rows_q[2] <= ROW2_RESET;
      rows_q[3] <= ROW3_RESET;
    end else if (cfg_we_i) begin
      case (vpd_reg_e'(cfg_idx_i))
        REG_ROW0: rows_q[0] <= cfg_wdata_i;
        REG_ROW1: rows_q[1] <= cfg_wdata_i;
        REG_ROW2: rows_q[2] <= cfg_wdata_i;
        REG_ROW3: rows_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vpd_matmul u_matmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_q),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .in_data_i   (vtx_i.data),
    .out_valid_o (mm_valid),
    .out_ready_i (mm_ready),
    .out_proj_o  (mm_proj)
  );

  vpd_div_prep u_div_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mm_valid),
    .in_ready_o  (mm_ready),
    .in_proj_i   (mm_proj),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_data_o  (div_data[0])
  );

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    vpd_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[g]),
      .in_ready_o  (div_ready[g]),
      .in_data_i   (div_data[g]),
      .out_valid_o (div_valid[g+1]),
      .out_ready_i (div_ready[g+1]),
      .out_data_o  (div_data[g+1])
    );
  end

  vpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid[QUO_W]),
    .in_ready_o  (div_ready[QUO_W]),
    .in_data_i   (div_data[QUO_W]),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_o.data)
  );

  // items in flight, for the checks below
  assign in_acc  = vtx_i.valid && vtx_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q < OCC_W'(PIPE_DEPTH)) |-> vtx_i.ready)
    else $error("input stalled while a pipeline stage is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.data.w_was_zero && (res_o.data.out_w == '0)) ||
                     (!res_o.data.w_was_zero && (res_o.data.out_w == Q_ONE))))
    else $error("out_w does not match the zero w flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> !res_o.valid)
    else $error("result shown with no item in flight");

endmodule

`default_nettype wire

[rtl/vpd_matmul.sv]
// matrix times vertex: lane products, pair sums, final sum with rounding to q22.16
`timescale 1ns / 1ps
`default_nettype none

module vpd_matmul import vpd_pkg::*; (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [LANES-1:0][ROW_W-1:0]    rows_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire vpd_vertex_t                    in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [LANES-1:0][PROJ_W-1:0]        out_proj_o
);

  logic signed [COORD_W-1:0] elem   [LANES];
  logic signed [COEF_W-1:0]  coef   [LANES][LANES];
  logic signed [PROD_W-1:0]  prod_d [LANES][LANES];
  logic signed [PROD_W-1:0]  prod_q [LANES][LANES];
  logic signed [PAIR_W-1:0]  pair_d [LANES][PAIRS];
  logic signed [PAIR_W-1:0]  pair_q [LANES][PAIRS];
  logic signed [ACC_W-1:0]   acc    [LANES];
  logic [LANES-1:0][PROJ_W-1:0] proj_q;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign elem[0] = in_data_i.in_x;
  assign elem[1] = in_data_i.in_y;
  assign elem[2] = in_data_i.in_z;
  assign elem[3] = in_data_i.in_w;

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      for (int k = 0; k < LANES; k++) begin
        coef[r][k]   = rows_i[r][COEF_W*k +: COEF_W];
        prod_d[r][k] = PROD_W'(coef[r][k]) * PROD_W'(elem[k]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      for (int j = 0; j < PAIRS; j++) begin
        pair_d[r][j] = PAIR_W'(prod_q[r][2*j]) + PAIR_W'(prod_q[r][2*j+1]);
      end
    end
  end

  // exact sum plus half, floor shift by the coefficient fraction
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      acc[r] = ACC_W'(pair_q[r][0]) + ACC_W'(pair_q[r][1]) + LANE_ROUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
    end
    if (en2) begin
      pair_q <= pair_d;
    end
    if (en3) begin
      for (int r = 0; r < LANES; r++) begin
        proj_q[r] <= acc[r][ACC_W-1:FRAC_COEF];
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_proj_o  = proj_q;

endmodule

`default_nettype wire

[rtl/vpd_div_prep.sv]
// divide setup: magnitudes and signs, rounded numerators, overflow check
`timescale 1ns / 1ps
`default_nettype none

module vpd_div_prep import vpd_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [LANES-1:0][PROJ_W-1:0] in_proj_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output vpd_div_t                         out_data_o
);

  logic [MAG_W-1:0] mag_d [DIV_LANES];
  logic [MAG_W-1:0] mag_q [DIV_LANES];
  logic             neg_d [DIV_LANES];
  logic             neg4_q [DIV_LANES];
  logic [MAG_W-1:0] dvs_d, dvs4_q;
  logic             wz_d, wz4_q;

  logic [NUM_W-1:0] num_d [DIV_LANES];
  logic [NUM_W-1:0] num_q [DIV_LANES];
  logic             neg5_q [DIV_LANES];
  logic [MAG_W-1:0] dvs5_q;
  logic             wz5_q;

  vpd_div_t div_d, div_q;

  logic v4_q, v5_q, v6_q;
  logic en4, en5, en6;

  assign en6        = !v6_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  always_comb begin
    wz_d = (in_proj_i[LANES-1] == '0);
    if (wz_d) begin
      dvs_d = MAG_W'(1);
    end else if (in_proj_i[LANES-1][PROJ_W-1]) begin
      dvs_d = MAG_W'(~in_proj_i[LANES-1] + PROJ_W'(1));
    end else begin
      dvs_d = MAG_W'(in_proj_i[LANES-1]);
    end
    for (int l = 0; l < DIV_LANES; l++) begin
      if (in_proj_i[l][PROJ_W-1]) begin
        mag_d[l] = MAG_W'(~in_proj_i[l] + PROJ_W'(1));
      end else begin
        mag_d[l] = MAG_W'(in_proj_i[l]);
      end
      neg_d[l] = in_proj_i[l][PROJ_W-1] ^ in_proj_i[LANES-1][PROJ_W-1];
    end
  end

  // zero w: divide the plain magnitude by one so the quotient is the value itself
  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      if (wz4_q) begin
        num_d[l] = NUM_W'(mag_q[l]);
      end else begin
        num_d[l] = (NUM_W'(mag_q[l]) << FRAC_COORD) + NUM_W'(dvs4_q >> 1);
      end
    end
  end

  always_comb begin
    div_d.dvs = dvs5_q;
    div_d.wz  = wz5_q;
    for (int l = 0; l < DIV_LANES; l++) begin
      div_d.lane[l].rem = MAG_W'(num_q[l][NUM_W-1:QUO_W]);
      div_d.lane[l].nq  = num_q[l][QUO_W-1:0];
      div_d.lane[l].neg = neg5_q[l];
      // quotient would not fit in the quotient width
      div_d.lane[l].ovf = (MAG_W'(num_q[l][NUM_W-1:QUO_W]) >= dvs5_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= in_valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      mag_q  <= mag_d;
      neg4_q <= neg_d;
      dvs4_q <= dvs_d;
      wz4_q  <= wz_d;
    end
    if (en5) begin
      num_q  <= num_d;
      neg5_q <= neg4_q;
      dvs5_q <= dvs4_q;
      wz5_q  <= wz4_q;
    end
    if (en6) begin
      div_q <= div_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = div_q;

endmodule

`default_nettype wire

[rtl/vpd_div_step.sv]
// one restoring divide step for all three lanes, one quotient bit each
`timescale 1ns / 1ps
`default_nettype none

module vpd_div_step import vpd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire vpd_div_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output vpd_div_t      out_data_o
);

  logic     valid_q;
  vpd_div_t data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    logic [MAG_W:0] part;
    data_d = in_data_i;
    for (int l = 0; l < DIV_LANES; l++) begin
      part = {in_data_i.lane[l].rem, in_data_i.lane[l].nq[QUO_W-1]};
      if (part >= {1'b0, in_data_i.dvs}) begin
        data_d.lane[l].rem = MAG_W'(part - {1'b0, in_data_i.dvs});
        data_d.lane[l].nq  = {in_data_i.lane[l].nq[QUO_W-2:0], 1'b1};
      end else begin
        data_d.lane[l].rem = MAG_W'(part);
        data_d.lane[l].nq  = {in_data_i.lane[l].nq[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[rtl/vpd_out_stage.sv]
// sign restore, clamp to q16.16 and result register
`timescale 1ns / 1ps
`default_nettype none

module vpd_out_stage import vpd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire vpd_div_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output vpd_result_t   out_data_o
);

  logic [COORD_W-1:0] val [DIV_LANES];
  logic               sat [DIV_LANES];
  logic               valid_q;
  vpd_result_t        res_d, res_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      if (in_data_i.lane[l].neg) begin
        sat[l] = in_data_i.lane[l].ovf || (in_data_i.lane[l].nq > COORD_MIN);
        val[l] = sat[l] ? COORD_MIN : (~in_data_i.lane[l].nq + COORD_W'(1));
      end else begin
        sat[l] = in_data_i.lane[l].ovf || in_data_i.lane[l].nq[QUO_W-1];
        val[l] = sat[l] ? COORD_MAX : in_data_i.lane[l].nq;
      end
    end
    res_d.out_x      = val[0];
    res_d.out_y      = val[1];
    res_d.out_z      = val[2];
    // w over itself is exactly one; a zero w gives zero
    res_d.out_w      = in_data_i.wz ? '0 : Q_ONE;
    res_d.w_was_zero = in_data_i.wz;
    res_d.saturated  = sat[0] || sat[1] || sat[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

[sim/vertex_projection_divide_test.sv]
// testbench for the vertex projection and perspective divide pipeline
`timescale 1ns / 1ps

module vertex_projection_divide_test;
  import vpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned HOLD_PHASE      = 6;

  // tracks the matrix and the projected vertices still due at the output
  class projection_scoreboard;
    logic [ROW_W-1:0] coef_rows [LANES];
    vpd_result_t      due_results [$];
    int unsigned      mismatches;

    function new();
      coef_rows[REG_ROW0] = ROW0_RESET;
      coef_rows[REG_ROW1] = ROW1_RESET;
      coef_rows[REG_ROW2] = ROW2_RESET;
      coef_rows[REG_ROW3] = ROW3_RESET;
      mismatches = 0;
    endfunction

    function void set_row(vpd_reg_e idx, logic [ROW_W-1:0] val);
      coef_rows[idx] = val;
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // exact dot product, then round Q22.28 to Q22.16 half toward plus infinity
    function longint project_row(logic [ROW_W-1:0] row, vpd_vertex_t v);
      longint elem [LANES];
      longint acc;
      longint coef;
      elem[0] = longint'(v.in_x);
      elem[1] = longint'(v.in_y);
      elem[2] = longint'(v.in_z);
      elem[3] = longint'(v.in_w);
      acc = 0;
      for (int k = 0; k < LANES; k++) begin
        coef = longint'($signed(row[COEF_W*k +: COEF_W]));
        acc += coef * elem[k];
      end
      return (acc + 2048) >>> FRAC_COEF;
    endfunction

    // magnitude divide rounded to nearest, ties away from zero
    function longint divide_q16(longint p, longint d);
      logic        neg;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      neg = (p < 0) != (d < 0);
      num = 64'(p < 0 ? -p : p) << FRAC_COORD;
      den = 64'(d < 0 ? -d : d);
      quo = (num + den / 2) / den;
      return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function logic [COORD_W-1:0] clamp_q16(longint v, inout bit sat);
      if (v > 64'sh7fff_ffff) begin
        sat = 1'b1;
        return COORD_MAX;
      end
      if (v < -64'sh8000_0000) begin
        sat = 1'b1;
        return COORD_MIN;
      end
      return v[COORD_W-1:0];
    endfunction

    function void note_vertex(vpd_vertex_t v);
      longint      proj [LANES];
      bit          wz;
      bit          sat;
      vpd_result_t r;
      for (int i = 0; i < LANES; i++) proj[i] = project_row(coef_rows[i], v);
      wz  = (proj[3] == 0);
      sat = 1'b0;
      r.out_x = clamp_q16(wz ? proj[0] : divide_q16(proj[0], proj[3]), sat);
      r.out_y = clamp_q16(wz ? proj[1] : divide_q16(proj[1], proj[3]), sat);
      r.out_z = clamp_q16(wz ? proj[2] : divide_q16(proj[2], proj[3]), sat);
      r.out_w = clamp_q16(wz ? proj[3] : divide_q16(proj[3], proj[3]), sat);
      r.w_was_zero = wz;
      r.saturated  = sat;
      due_results.push_back(r);
    endfunction

    function void check_result(vpd_result_t got);
      vpd_result_t exp_r;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result with no vertex pending: x=%h y=%h z=%h w=%h wz=%b sat=%b",
                   got.out_x, got.out_y, got.out_z, got.out_w, got.w_was_zero, got.saturated);
        return;
      end
      exp_r = due_results.pop_front();
      if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
          got.out_z !== exp_r.out_z || got.out_w !== exp_r.out_w ||
          got.w_was_zero !== exp_r.w_was_zero || got.saturated !== exp_r.saturated) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch expected: x=%h y=%h z=%h w=%h wz=%b sat=%b",
                   exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.out_w,
                   exp_r.w_was_zero, exp_r.saturated);
          $display("         actual:   x=%h y=%h z=%h w=%h wz=%b sat=%b",
                   got.out_x, got.out_y, got.out_z, got.out_w,
                   got.w_was_zero, got.saturated);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ROW_W-1:0]     cfg_wdata_i;

  vpd_stream_if #(.payload_t(vpd_vertex_t)) vtx ();
  vpd_stream_if #(.payload_t(vpd_result_t)) res ();

  vertex_projection_divide uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vtx_i       (vtx),
    .res_o       (res)
  );

  projection_scoreboard sb = new();

  int unsigned tx_mode = 1;
  int unsigned rx_mode = 1;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vertex_projection_divide_test failed");
      $finish;
    end
  end

  // 0: never idle, 1: a random gap before every item, 2: occasional gaps
  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 10);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return COEF_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h1000;
          default: return 16'hf000;
        endcase
      end
      default: return COEF_W'($urandom_range(0, 16'h4000) - 16'h2000);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] row;
    for (int k = 0; k < LANES; k++) row[COEF_W*k +: COEF_W] = rand_coef();
    return row;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] mag;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 6))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          4: return 32'hffff_0000;
          5: return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        // spread magnitudes over every scale
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic vpd_vertex_t make_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                              logic [COORD_W-1:0] z, logic [COORD_W-1:0] w);
    vpd_vertex_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  function automatic vpd_vertex_t rand_vertex();
    vpd_vertex_t v;
    v = make_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    if ($urandom_range(0, 7) == 0) v.in_w = '0;
    if ($urandom_range(0, 7) == 0) v.in_z = '0;
    return v;
  endfunction

  task automatic send_vertex(input vpd_vertex_t v);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.data  <= v;
    do @(posedge clk_i); while (!vtx.ready);
    sb.note_vertex(v);
  endtask

  // sender stops and waits for every projected vertex to come back
  task automatic wait_drained();
    vtx.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic write_row(input vpd_reg_e idx, input logic [ROW_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_row(idx, val);
  endtask

  task automatic write_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3);
    write_row(REG_ROW0, r0);
    write_row(REG_ROW1, r1);
    write_row(REG_ROW2, r2);
    write_row(REG_ROW3, r3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side
  initial begin
    int unsigned stall;
    res.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_gap(rx_mode);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      sb.check_result(res.data);
    end
  end

  initial begin
    logic [ROW_W-1:0] rows [LANES];
    vtx.valid   <= 1'b0;
    vtx.data    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ROW0;
    cfg_wdata_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix from reset: plain divides, rounding, zero w, clamping
    send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 32'h0001_0000));
    send_vertex(make_vertex(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0001_0000));
    send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000));
    send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001));
    send_vertex(make_vertex(32'h0000_0005, 32'hffff_fff9, 32'h7fff_ffff, 32'h0));
    send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 32'h0));
    send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_0000));
    send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000));
    send_vertex(make_vertex(32'h0000_0001, 32'hffff_ffff, 32'h0, 32'hffff_ffff));
    send_vertex(make_vertex(32'h0000_0001, 32'h0000_0002, 32'hffff_ffff, 32'h0000_0003));
    send_vertex(make_vertex(32'h0000_0001, 32'hffff_ffff, 32'h0000_0003, 32'h0000_0002));
    send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff));
    send_vertex(make_vertex(32'h0000_8000, 32'hffff_8000, 32'h0001_8000, 32'h0002_0000));
    send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_vertex(make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_vertex(make_vertex(32'h8000_0000, 32'h0, 32'h0, 32'h0));

    for (int unsigned phase = 1; phase <= PHASES; phase++) begin
      wait_drained();
      case (phase)
        2: for (int i = 0; i < LANES; i++) rows[i] = 64'h7fff_7fff_7fff_7fff;
        3: for (int i = 0; i < LANES; i++) rows[i] = 64'h8000_8000_8000_8000;
        4: for (int i = 0; i < LANES; i++) rows[i] = '0;
        5: begin
          // perspective shape: w comes from minus z, so zero z gives zero w
          rows[0] = {48'h0, rand_coef()};
          rows[1] = {32'h0, rand_coef(), 16'h0};
          rows[2] = {rand_coef(), rand_coef(), 32'h0};
          rows[3] = {16'h0, 16'hf000, 32'h0};
        end
        default: for (int i = 0; i < LANES; i++) rows[i] = rand_row();
      endcase
      write_matrix(rows[0], rows[1], rows[2], rows[3]);

      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      if (phase == HOLD_PHASE) begin
        // long output stall while the input keeps coming
        tx_mode  = 0;
        hold_req = 1'b1;
      end
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) send_vertex(rand_vertex());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("vertex_projection_divide_test passed");
    end else begin
      $display("vertex_projection_divide_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vpd_pkg.sv
rtl/vpd_stream_if.sv
rtl/vpd_matmul.sv
rtl/vpd_div_prep.sv
rtl/vpd_div_step.sv
rtl/vpd_out_stage.sv
rtl/vertex_projection_divide.sv
sim/vertex_projection_divide_test.sv
